// ----- sv/dlpm_pkg.sv -----
// Package: shared types and constants for the DAWG longest-prefix lookup.
`timescale 1ns / 1ps

package dlpm_pkg;

    localparam int TABLE_DEPTH_DEF   = 65536;
    localparam int ALPHABET_SIZE_DEF = 26;

    localparam int NODE_W   = 16;
    localparam int LETTER_W = 8;
    localparam int POS_W    = 8;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_CHAR = 1'b1;

    localparam logic [LETTER_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [LETTER_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [LETTER_W-1:0] CASE_OFFSET  = 8'h20;
    localparam logic [POS_W-1:0]    POS_MAX      = 8'hFF;

    typedef struct packed {
        logic                kind;
        logic [NODE_W-1:0]   node_address;
        logic [LETTER_W-1:0] node_letter;
        logic                node_is_word;
        logic                node_list_end;
        logic [NODE_W-1:0]   node_child;
        logic [LETTER_W-1:0] word_char;
        logic                last_char;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0] match_length;
        logic             full_match;
    } out_item_t;

    // one table entry, 26 bits
    typedef struct packed {
        logic [NODE_W-1:0]   child;
        logic                list_end;
        logic                is_word;
        logic [LETTER_W-1:0] letter;
    } node_t;

    localparam int ENTRY_W = $bits(node_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

endpackage

// ----- sv/dlpm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module dlpm_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/dawg_longest_prefix_match.sv -----
// Top level: DAWG word lookup giving the longest dictionary-word prefix of a streamed word.
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Carries
// s_        in         s_valid / s_ready   in_item_t: node load or one word character
// m_        out        m_valid / m_ready   out_item_t: prefix length and whole-word flag
// cfg_      in         cfg_valid/cfg_ready root index of the graph, 16 bits
//
// Steps: a load item is written to the node table when it is accepted. A character
//   item reads one node of its sibling list per scan step (1 to ALPHABET_SIZE
//   nodes) through the single read port of the node table; the last character
//   then passes through ST_EMIT to hand over its result.
// Dead words (after a mismatch) skip the table walk for each character.
// Reset (aresetn low, synchronous) clears the word state and the root index;
//   the node table is not cleared and must be loaded before use.
// A stalled m_ channel is felt only once the next word's final character has
//   been walked: s_ready then stays low until the held item leaves.
// TABLE_DEPTH must be a power of two; node indices are taken modulo it.

module dawg_longest_prefix_match
#(
    parameter int TABLE_DEPTH   = dlpm_pkg::TABLE_DEPTH_DEF,
    parameter int ALPHABET_SIZE = dlpm_pkg::ALPHABET_SIZE_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  dlpm_pkg::in_item_t         s_data,

    output logic                       m_valid,
    input  logic                       m_ready,
    output dlpm_pkg::out_item_t        m_data,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [dlpm_pkg::NODE_W-1:0] cfg_data
);

    import dlpm_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(ALPHABET_SIZE + 1);

    // control and word state
    state_t            state_reg, state_next;
    logic [NODE_W-1:0] root_reg;
    logic [NODE_W-1:0] cur_reg,   cur_next;
    logic [POS_W-1:0]  pos_reg,   pos_next;
    logic [POS_W-1:0]  best_reg,  best_next;
    logic              dead_reg,  dead_next;
    logic              full_reg,  full_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              m_valid_reg, m_valid_next;

    // payload
    logic [LETTER_W-1:0] ch_reg,   ch_next;
    logic                last_reg, last_next;
    logic [NODE_W-1:0]   scan_reg, scan_next;
    out_item_t           m_data_reg, m_data_next;

    // table access
    logic              rd_issue;
    logic [NODE_W-1:0] rd_node;
    logic              wr_en;
    node_t             wr_entry;
    node_t             rd_entry;
    logic [ENTRY_W-1:0] rd_raw;

    logic                accept;
    logic [LETTER_W-1:0] ch_fold;
    logic [POS_W-1:0]    pos_inc;
    logic                hit;
    logic                out_free;

    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign pos_inc   = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 1'b1;

    // upper case letters only are folded
    assign ch_fold = (s_data.word_char >= CHAR_UPPER_A && s_data.word_char <= CHAR_UPPER_Z)
                   ? s_data.word_char + CASE_OFFSET : s_data.word_char;

    assign wr_en    = accept && (s_data.kind == KIND_LOAD);
    assign wr_entry = '{child:    s_data.node_child,
                        list_end: s_data.node_list_end,
                        is_word:  s_data.node_is_word,
                        letter:   s_data.node_letter};

    assign rd_entry = node_t'(rd_raw);
    assign hit      = (rd_entry.letter == ch_reg);

    dlpm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(s_data.node_address)),
        .wr_data (wr_entry),
        .rd_addr (AW'(rd_node)),
        .rd_data (rd_raw)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            root_reg    <= '0;
            cur_reg     <= '0;
            pos_reg     <= '0;
            best_reg    <= '0;
            dead_reg    <= 1'b0;
            full_reg    <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            pos_reg     <= pos_next;
            best_reg    <= best_next;
            dead_reg    <= dead_next;
            full_reg    <= full_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                root_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ch_reg     <= ch_next;
        last_reg   <= last_next;
        scan_reg   <= scan_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        pos_next     = pos_reg;
        best_next    = best_reg;
        dead_next    = dead_reg;
        full_next    = full_reg;
        count_next   = count_reg;
        ch_next      = ch_reg;
        last_next    = last_reg;
        scan_next    = scan_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        rd_issue     = 1'b0;
        rd_node      = scan_reg;
        s_ready      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                // first character of a word starts from the root list
                rd_node = (pos_reg == '0) ? root_reg : cur_reg;
                if (s_valid && s_data.kind == KIND_CHAR) begin
                    ch_next   = ch_fold;
                    last_next = s_data.last_char;
                    full_next = 1'b0;
                    if (dead_reg) begin
                        pos_next   = pos_inc;
                        state_next = s_data.last_char ? ST_EMIT : ST_IDLE;
                    end else begin
                        rd_issue   = 1'b1;
                        scan_next  = rd_node;
                        count_next = CW'(1);
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                rd_node = scan_reg + 1'b1;
                if (hit) begin
                    cur_next = rd_entry.child;
                    if (rd_entry.is_word) begin
                        best_next = pos_inc;
                        full_next = 1'b1;
                    end
                    pos_next   = pos_inc;
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end else if (rd_entry.list_end || count_reg == CW'(ALPHABET_SIZE)) begin
                    dead_next  = 1'b1;
                    pos_next   = pos_inc;
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end else begin
                    // next sibling, index wraps at 16 bits
                    rd_issue   = 1'b1;
                    scan_next  = rd_node;
                    count_next = count_reg + 1'b1;
                end
            end

            ST_EMIT: begin
                if (out_free) begin
                    m_data_next  = '{match_length: best_reg, full_match: full_reg};
                    m_valid_next = 1'b1;
                    pos_next     = '0;
                    best_next    = '0;
                    dead_next    = 1'b0;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a scan stays within one sibling list's bound
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> (count_reg != '0 && count_reg <= CW'(ALPHABET_SIZE)))
        else $error("sibling scan beyond alphabet bound");

    // no table walk for a word already dead
    a_dead_no_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> !dead_reg)
        else $error("scan on dead word");

    // load items leave the word state alone
    a_load_keeps_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.kind == KIND_LOAD) |=>
            ($stable(pos_reg) && $stable(best_reg) && $stable(dead_reg)))
        else $error("load item changed word state");

    // handing over a result clears the word and shows the item
    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free) |=>
            (m_valid && pos_reg == '0 && best_reg == '0 && !dead_reg))
        else $error("result hand-over did not reset word");

    // every read issue leads to a scan step in the next cycle
    a_read_then_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_issue |=> state_reg == ST_SCAN)
        else $error("read issued without scan step");

endmodule
